FILE: rtl/ssw_pkg.sv
// Shared types and constants for the sync-write packet framer.
package ssw_pkg;

  // Packet framing bytes
  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] BCAST_ID  = 8'hFE;
  localparam logic [7:0] START_ADDR = 8'h1E;
  localparam logic [7:0] DATA_LEN  = 8'h02;

  // Servo count limits
  localparam logic [6:0] MAX_COUNT = 7'd83;
  localparam logic [6:0] MIN_COUNT = 7'd1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSTR_CODE  = 1'd1;

  // Register reset values
  localparam logic [6:0] COUNT_RST = 7'd1;
  localparam logic [7:0] INSTR_RST = 8'h83;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Byte positions within one entry's burst
  localparam logic [3:0] STEP_HDR0  = 4'd0;
  localparam logic [3:0] STEP_HDR1  = 4'd1;
  localparam logic [3:0] STEP_BCAST = 4'd2;
  localparam logic [3:0] STEP_LEN   = 4'd3;
  localparam logic [3:0] STEP_INSTR = 4'd4;
  localparam logic [3:0] STEP_ADDR  = 4'd5;
  localparam logic [3:0] STEP_DLEN  = 4'd6;
  localparam logic [3:0] STEP_ID    = 4'd7;
  localparam logic [3:0] STEP_POSL  = 4'd8;
  localparam logic [3:0] STEP_POSH  = 4'd9;
  localparam logic [3:0] STEP_CSUM  = 4'd10;

  // One classified entry, handed from front to back
  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] goal_position;
    logic        first;
    logic        last;
    logic [7:0]  len_byte;
    logic [7:0]  instr;
  } cmd_t;

endpackage

FILE: rtl/ssw_front.sv
// Front end: configuration registers, entry accept and packet classification.
module ssw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // entry stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    servo_id_i,
  input  logic [15:0]                   goal_position_i,
  // queue push side
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output ssw_pkg::cmd_t                 q_cmd_o
);

  logic [6:0] servo_count_q;
  logic [7:0] instr_code_q;
  logic [6:0] entry_idx_q, entry_idx_d;
  logic [6:0] count_eff;
  logic [7:0] idx_inc;
  logic [7:0] len_byte;
  logic       is_first, is_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  // Clamp count into the legal range
  always_comb begin
    if (servo_count_q == 7'd0) begin
      count_eff = ssw_pkg::MIN_COUNT;
    end else if (servo_count_q > ssw_pkg::MAX_COUNT) begin
      count_eff = ssw_pkg::MAX_COUNT;
    end else begin
      count_eff = servo_count_q;
    end
  end

  // Length byte 3*count+4; at most 253
  assign len_byte = {count_eff, 1'b0} + {1'b0, count_eff} + 8'd4;

  // Classify the entry
  assign idx_inc  = {1'b0, entry_idx_q} + 8'd1;
  assign is_first = (entry_idx_q == 7'd0);
  assign is_last  = (idx_inc >= {1'b0, count_eff});
  assign entry_idx_d = is_last ? 7'd0 : idx_inc[6:0];

  always_comb begin
    q_cmd_o.servo_id      = servo_id_i;
    q_cmd_o.goal_position = goal_position_i;
    q_cmd_o.first         = is_first;
    q_cmd_o.last          = is_last;
    q_cmd_o.len_byte      = len_byte;
    q_cmd_o.instr         = instr_code_q;
  end

  // Registers and entry position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_count_q <= ssw_pkg::COUNT_RST;
      instr_code_q  <= ssw_pkg::INSTR_RST;
      entry_idx_q   <= 7'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ssw_pkg::REG_SERVO_COUNT: servo_count_q <= cfg_data_i[6:0];
          ssw_pkg::REG_INSTR_CODE:  instr_code_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (q_push_o) begin
        entry_idx_q <= entry_idx_d;
      end
    end
  end

endmodule

FILE: rtl/ssw_queue.sv
// Short queue of classified entries between front and back.
module ssw_queue #(
  parameter int unsigned Depth = ssw_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssw_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ssw_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ssw_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/ssw_back.sv
// Back end: byte sequencer, checksum accumulator and output register.
module ssw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  // queue pop side
  input  logic          q_empty_i,
  input  ssw_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  // byte stream
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    tx_byte_o,
  output logic          packet_end_o
);

  logic [3:0] step_q, step_d;
  logic [3:0] cur_step;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cur_byte;
  logic       emit;
  logic       entry_done;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       end_q;

  // Later entries of a packet skip the header
  assign cur_step = (step_q == ssw_pkg::STEP_HDR0 && !q_head_i.first) ?
                    ssw_pkg::STEP_ID : step_q;

  assign emit = !q_empty_i && (!out_valid_q || out_ready_i);

  // Byte select
  always_comb begin
    unique case (cur_step) inside
      ssw_pkg::STEP_HDR0,
      ssw_pkg::STEP_HDR1:  cur_byte = ssw_pkg::HDR_BYTE;
      ssw_pkg::STEP_BCAST: cur_byte = ssw_pkg::BCAST_ID;
      ssw_pkg::STEP_LEN:   cur_byte = q_head_i.len_byte;
      ssw_pkg::STEP_INSTR: cur_byte = q_head_i.instr;
      ssw_pkg::STEP_ADDR:  cur_byte = ssw_pkg::START_ADDR;
      ssw_pkg::STEP_DLEN:  cur_byte = ssw_pkg::DATA_LEN;
      ssw_pkg::STEP_ID:    cur_byte = q_head_i.servo_id;
      ssw_pkg::STEP_POSL:  cur_byte = q_head_i.goal_position[7:0];
      ssw_pkg::STEP_POSH:  cur_byte = q_head_i.goal_position[15:8];
      ssw_pkg::STEP_CSUM:  cur_byte = ~sum_q;
      default:             cur_byte = ssw_pkg::HDR_BYTE;
    endcase
  end

  // Entry finishes on its high position byte, or on the checksum
  assign entry_done = (cur_step == ssw_pkg::STEP_CSUM) ||
                      (cur_step == ssw_pkg::STEP_POSH && !q_head_i.last);
  assign q_pop_o    = emit && entry_done;
  assign step_d     = entry_done ? ssw_pkg::STEP_HDR0 : cur_step + 4'd1;

  // Checksum restarts at the broadcast ID
  always_comb begin
    if (cur_step == ssw_pkg::STEP_BCAST) begin
      sum_d = ssw_pkg::BCAST_ID;
    end else if (cur_step >= ssw_pkg::STEP_LEN && cur_step <= ssw_pkg::STEP_POSH) begin
      sum_d = sum_q + cur_byte;
    end else begin
      sum_d = sum_q;
    end
  end

  // Sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ssw_pkg::STEP_HDR0;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        step_q      <= step_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= cur_byte;
      end_q  <= (cur_step == ssw_pkg::STEP_CSUM);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = byte_q;
  assign packet_end_o = end_q;

endmodule

FILE: rtl/servo_sync_write_framer.sv
// Top level of the sync-write packet framer.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+----------------------------------------
//  s_axis   | in  | tvalid/tready           | tdata[7:0] servo_id, [23:8] goal_position
//  m_axis   | out | tvalid/tready           | tdata[7:0] tx_byte, tlast packet_end
//  cfg      | in  | valid/ready             | index 0 servo_count, 1 instruction_code
//
// One byte leaves per cycle from the output register while m_axis is ready and
// the queue holds an entry. A packet's first entry yields 10 bytes (11 if it
// also closes the packet), later entries 3, the closing entry 4, from the byte sequencer.
// The queue takes new entries while the back end works; ready drops only when
// it is full. Reset is asynchronous, active low, and needs no clearing pass.
// A stall on m_axis holds the output byte and backs up into the queue.
module servo_sync_write_framer #(
  parameter int unsigned QueueDepth = ssw_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // entry stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [23:0]                   s_axis_tdata_i,  // [7:0] servo_id, [23:8] goal_position
  // byte stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // [7:0] tx_byte
  output logic                          m_axis_tlast_o,  // packet_end
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  logic          q_push, q_full, q_pop, q_empty;
  ssw_pkg::cmd_t push_cmd, head_cmd;

  // Accept and classify
  ssw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .servo_id_i      (s_axis_tdata_i[7:0]),
    .goal_position_i (s_axis_tdata_i[23:8]),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  // Entry queue
  ssw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  // Byte sequencer
  ssw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (head_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .tx_byte_o    (m_axis_tdata_o),
    .packet_end_o (m_axis_tlast_o)
  );

endmodule

FILE: rtl/ssw_checker.sv
// Port-level checks on the framer's byte stream, bound to the top level.
module ssw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic boundary_q;

  // Set between packets: after reset and after a closing word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= 1'b1;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      boundary_q <= m_axis_tlast_o;
    end
  end

  // A packet opens with the header byte
  a_open_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && boundary_q |-> m_axis_tdata_o == ssw_pkg::HDR_BYTE)
    else $error("packet does not open with header byte");

  // The opening word never closes a packet
  a_no_empty_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && boundary_q |-> !m_axis_tlast_o)
    else $error("packet closed on its first word");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output word changed");

  // A waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("waiting input word changed");

endmodule

bind servo_sync_write_framer ssw_checker u_ssw_checker (.*);

FILE: sim/ssw_packet_monitor.sv
// Monitor for the sync-write framer: predicts every packet byte and checks the byte stream.
module ssw_packet_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // entry stream, as seen on the ports
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [23:0]                   s_axis_tdata_i,  // [7:0] servo_id, [23:8] goal_position
  // byte stream, as seen on the ports
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [7:0]                    m_axis_tdata_i,  // [7:0] tx_byte
  input  logic                          m_axis_tlast_i,  // packet_end
  // register writes, as seen on the ports
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // status for the stimulus side
  output int                            pending_o,
  output int                            mismatches_o
);

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
  } pkt_byte_t;

  pkt_byte_t  packet_bytes_q[$];
  pkt_byte_t  want;
  logic [6:0] servo_count_q;
  logic [7:0] instr_code_q;
  logic [6:0] entries_sent;
  logic [7:0] byte_sum;
  int         mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // One line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("%0t: %s: got %02h, want %02h", $time, what, got, exp_val);
    mismatch_cnt++;
  endtask

  // Queue one packet byte; summed bytes feed the checksum
  task automatic push_packet_byte(input logic [7:0] b, input logic last, input logic summed);
    packet_bytes_q.push_back('{tx_byte: b, packet_end: last});
    if (summed) begin
      byte_sum = byte_sum + b;
    end
  endtask

  // Bytes that one accepted entry produces
  task automatic frame_entry(input logic [7:0] id, input logic [15:0] pos);
    logic [6:0] eff_count;
    logic [7:0] len_byte;
    eff_count = servo_count_q;
    if (eff_count < ssw_pkg::MIN_COUNT) begin
      eff_count = ssw_pkg::MIN_COUNT;
    end
    if (eff_count > ssw_pkg::MAX_COUNT) begin
      eff_count = ssw_pkg::MAX_COUNT;
    end
    len_byte = {1'b0, eff_count} * 8'd3 + 8'd4;
    // header only on the first entry of a packet
    if (entries_sent == '0) begin
      byte_sum = '0;
      push_packet_byte(ssw_pkg::HDR_BYTE, 1'b0, 1'b0);
      push_packet_byte(ssw_pkg::HDR_BYTE, 1'b0, 1'b0);
      push_packet_byte(ssw_pkg::BCAST_ID, 1'b0, 1'b1);
      push_packet_byte(len_byte, 1'b0, 1'b1);
      push_packet_byte(instr_code_q, 1'b0, 1'b1);
      push_packet_byte(ssw_pkg::START_ADDR, 1'b0, 1'b1);
      push_packet_byte(ssw_pkg::DATA_LEN, 1'b0, 1'b1);
    end
    push_packet_byte(id, 1'b0, 1'b1);
    push_packet_byte(pos[7:0], 1'b0, 1'b1);
    push_packet_byte(pos[15:8], 1'b0, 1'b1);
    entries_sent = entries_sent + 7'd1;
    // close the packet once the count is reached, also when it shrank mid-packet
    if (entries_sent >= eff_count) begin
      push_packet_byte(~byte_sum, 1'b1, 1'b0);
      entries_sent = '0;
      byte_sum     = '0;
    end
  endtask

  // Track register writes, predict on accepted entries, compare accepted bytes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_count_q = ssw_pkg::COUNT_RST;
      instr_code_q  = ssw_pkg::INSTR_RST;
      entries_sent  = '0;
      byte_sum      = '0;
      packet_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == ssw_pkg::REG_SERVO_COUNT) begin
          servo_count_q = cfg_data_i[6:0];
        end else if (cfg_index_i == ssw_pkg::REG_INSTR_CODE) begin
          instr_code_q = cfg_data_i;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        frame_entry(s_axis_tdata_i[7:0], s_axis_tdata_i[23:8]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (packet_bytes_q.size() == 0) begin
          report_mismatch("byte with nothing pending", m_axis_tdata_i, 8'h00);
        end else begin
          want = packet_bytes_q.pop_front();
          if (m_axis_tdata_i !== want.tx_byte) begin
            report_mismatch("tx_byte", m_axis_tdata_i, want.tx_byte);
          end
          if (m_axis_tlast_i !== want.packet_end) begin
            report_mismatch("packet_end", {7'd0, m_axis_tlast_i}, {7'd0, want.packet_end});
          end
        end
      end
      pending_o <= packet_bytes_q.size();
    end
  end

endmodule

FILE: sim/servo_sync_write_framer_test.sv
// Testbench top for the sync-write framer: entry and register stimulus, verdict.
module servo_sync_write_framer_test;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [23:0]                   s_tdata   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [7:0]                    m_tdata;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ssw_pkg::CFG_IDX_W-1:0] cfg_index = ssw_pkg::REG_SERVO_COUNT;
  logic [7:0]                    cfg_data  = '0;
  int                            pending;
  int                            mismatches;
  int                            cycle_cnt     = 0;
  int                            send_idle_pct = 38;
  int                            rcv_idle_pct  = 71;

  always #5 clk_i = ~clk_i;

  servo_sync_write_framer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  ssw_packet_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  // Byte sink stalls at random
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stop sending and wait until every predicted byte has left
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Register write, only with the framer idle
  task automatic write_reg(input logic [ssw_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One entry word, after a random gap
  task automatic send_entry(input logic [7:0] id, input logic [15:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, id};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Random entries with occasional register writes, some of them mid-packet
  task automatic run_random(input int n_items, input int s_idle, input int r_idle);
    logic [7:0]  id;
    logic [15:0] pos;
    int          roll;
    send_idle_pct = s_idle;
    rcv_idle_pct  = r_idle;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(ssw_pkg::REG_INSTR_CODE, 8'($urandom_range(0, 255)));
        end else begin
          roll = $urandom_range(0, 39);
          // mostly short packets, now and then zero or at or above the maximum
          if (roll < 3) begin
            write_reg(ssw_pkg::REG_SERVO_COUNT, {1'($urandom_range(0, 1)), 7'd0});
          end else if (roll == 3) begin
            write_reg(ssw_pkg::REG_SERVO_COUNT,
                      {1'($urandom_range(0, 1)), 7'($urandom_range(83, 127))});
          end else if (roll < 10) begin
            write_reg(ssw_pkg::REG_SERVO_COUNT,
                      {1'($urandom_range(0, 1)), 7'($urandom_range(7, 20))});
          end else begin
            write_reg(ssw_pkg::REG_SERVO_COUNT,
                      {1'($urandom_range(0, 1)), 7'($urandom_range(1, 6))});
          end
        end
      end
      roll = $urandom_range(0, 7);
      id   = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 7);
      pos  = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      send_entry(id, pos);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one servo per packet, default instruction
    send_entry(8'h00, 16'h0000);
    send_entry(8'hFF, 16'hFFFF);
    // three servos, instruction zero
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'd3);
    write_reg(ssw_pkg::REG_INSTR_CODE, 8'h00);
    send_entry(8'h01, 16'h00FF);
    send_entry(8'hFE, 16'hFF00);
    send_entry(8'h80, 16'h8001);
    // count zero acts as one
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'd0);
    write_reg(ssw_pkg::REG_INSTR_CODE, 8'hFF);
    send_entry(8'h7F, 16'h7FFF);
    // count above the maximum, with the unused top bit set
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'hD4);
    send_entry(8'h12, 16'h3456);
    send_entry(8'hAB, 16'hCDEF);
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'd83);
    send_entry(8'h55, 16'hAAAA);
    // count drops below entries sent; the instruction waits for the next packet
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'd2);
    write_reg(ssw_pkg::REG_INSTR_CODE, 8'h5A);
    send_entry(8'hAA, 16'h5555);
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'h7F);
    send_entry(8'h3C, 16'hC3C3);
    write_reg(ssw_pkg::REG_SERVO_COUNT, 8'd1);
    send_entry(8'hC3, 16'h3C3C);

    run_random(99, 38, 71);
    run_random(99, 71, 38);
    run_random(98, 0, 0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
